>>> rtl/servo_ordered_ramp_sequencer_assert.svh
// Assertion macros for the servo ordered ramp sequencer checker.
// Expects clk and rst in the scope of use.
`ifndef SERVO_ORDERED_RAMP_SEQUENCER_ASSERT_SVH
`define SERVO_ORDERED_RAMP_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SORS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sors check failed");

// next-cycle implication
`define SORS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sors check failed");

`endif

>>> rtl/sors_pkg.sv
// Shared types and constants of the servo ordered ramp sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sors_pkg;

  localparam int NUM_SERVOS  = 6;
  localparam int SERVO_SLOTS = 8;
  localparam int ORDER_SLOTS = 6;
  localparam int NUM_W       = 3;
  localparam int ANGLE_W     = 8;
  localparam int ORDER_W     = ORDER_SLOTS * NUM_W;
  localparam int TICKS_W     = 15;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [NUM_W-1:0]   servo_index;
    logic [ANGLE_W-1:0] target_position;
    logic [ORDER_W-1:0] move_order;
    logic [TICKS_W-1:0] step_ticks;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [NUM_W-1:0]   servo_out;
    logic [ANGLE_W-1:0] angle;
  } result_t;

  function automatic logic [ANGLE_W-1:0] home_pos(input logic [NUM_W-1:0] idx);
    logic [ANGLE_W-1:0] pos;
    case (idx)
      3'd0:    pos = 8'd76;
      3'd1:    pos = 8'd21;
      3'd2:    pos = 8'd12;
      3'd3:    pos = 8'd14;
      3'd4:    pos = 8'd11;
      3'd5:    pos = 8'd37;
      default: pos = 8'd0;
    endcase
    return pos;
  endfunction

endpackage

>>> rtl/sors_in_reg.sv
// Request input register of the servo ordered ramp sequencer.
// Depends on sors_pkg.
`timescale 1ns / 1ps

module sors_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sors_pkg::item_t req_item,
  input  logic           fire,
  output logic           item_valid,
  output sors_pkg::item_t item
);

  assign req_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req_item;
    end
  end

endmodule

>>> rtl/sors_core.sv
// Sequencer state and its combinational update for one request.
// Depends on sors_pkg.
`timescale 1ns / 1ps

module sors_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  sors_pkg::item_t  item,
  output logic             has_res,
  output sors_pkg::result_t res
);

  logic [sors_pkg::ANGLE_W-1:0] last_pos [sors_pkg::SERVO_SLOTS];
  logic [sors_pkg::ANGLE_W-1:0] tgt      [sors_pkg::SERVO_SLOTS];
  logic [sors_pkg::ORDER_W-1:0] order;
  logic [sors_pkg::NUM_W-1:0]   slot;
  logic [sors_pkg::ANGLE_W-1:0] cur;
  logic [sors_pkg::TICKS_W-1:0] wait_cnt;
  logic [sors_pkg::TICKS_W-1:0] delay;
  logic                         running;
  logic                         ramping;

  logic [sors_pkg::ANGLE_W-1:0] last_pos_next [sors_pkg::SERVO_SLOTS];
  logic [sors_pkg::ANGLE_W-1:0] tgt_next      [sors_pkg::SERVO_SLOTS];
  logic [sors_pkg::ORDER_W-1:0] order_next;
  logic [sors_pkg::NUM_W-1:0]   slot_next;
  logic [sors_pkg::ANGLE_W-1:0] cur_next;
  logic [sors_pkg::TICKS_W-1:0] wait_cnt_next;
  logic [sors_pkg::TICKS_W-1:0] delay_next;
  logic                         running_next;
  logic                         ramping_next;

  logic [sors_pkg::SERVO_SLOTS-1:0] differs;
  logic [sors_pkg::ORDER_SLOTS-1:0] work;
  logic                             found;
  logic [sors_pkg::NUM_W-1:0]       found_slot;
  logic [sors_pkg::NUM_W-1:0]       sel_slot;
  logic [sors_pkg::NUM_W-1:0]       sel_num;
  logic [sors_pkg::NUM_W-1:0]       sel_servo;
  logic [sors_pkg::ANGLE_W-1:0]     cur_ang;
  logic [sors_pkg::ANGLE_W-1:0]     tgt_ang;

  always_comb begin
    logic [sors_pkg::NUM_W-1:0] num;
    for (int i = 0; i < sors_pkg::SERVO_SLOTS; i++) begin
      differs[i] = tgt[i] != last_pos[i];
    end
    for (int k = 0; k < sors_pkg::ORDER_SLOTS; k++) begin
      num = order[k*sors_pkg::NUM_W +: sors_pkg::NUM_W];
      work[k] = (num != '0) && (num <= sors_pkg::NUM_W'(sors_pkg::NUM_SERVOS)) &&
                differs[num - 3'd1];
    end
  end

  // first slot at or after the current one that has a move to make
  always_comb begin
    found = 1'b0;
    found_slot = '0;
    for (int k = sors_pkg::ORDER_SLOTS - 1; k >= 0; k--) begin
      if (work[k] && (sors_pkg::NUM_W'(k) >= slot)) begin
        found = 1'b1;
        found_slot = sors_pkg::NUM_W'(k);
      end
    end
  end

  always_comb begin
    sel_slot = ramping ? slot : found_slot;
    sel_num = '0;
    for (int k = 0; k < sors_pkg::ORDER_SLOTS; k++) begin
      if (sel_slot == sors_pkg::NUM_W'(k)) begin
        sel_num = order[k*sors_pkg::NUM_W +: sors_pkg::NUM_W];
      end
    end
    sel_servo = sel_num - 3'd1;
    cur_ang = ramping ? cur : last_pos[sel_servo];
    tgt_ang = tgt[sel_servo];
  end

  always_comb begin
    last_pos_next = last_pos;
    tgt_next      = tgt;
    order_next    = order;
    slot_next     = slot;
    cur_next      = cur;
    wait_cnt_next = wait_cnt;
    delay_next    = delay;
    running_next  = running;
    ramping_next  = ramping;
    has_res       = 1'b0;
    res           = '0;
    if (fire) begin
      case (item.mode)
        sors_pkg::MODE_LOAD: begin
          if (!running &&
              item.servo_index < sors_pkg::NUM_W'(sors_pkg::NUM_SERVOS)) begin
            tgt_next[item.servo_index] = item.target_position;
          end
        end
        sors_pkg::MODE_START: begin
          if (!running) begin
            order_next    = item.move_order;
            delay_next    = item.step_ticks;
            slot_next     = '0;
            wait_cnt_next = '0;
            cur_next      = '0;
            ramping_next  = 1'b0;
            running_next  = 1'b1;
          end
        end
        sors_pkg::MODE_TICK: begin
          if (running) begin
            if (wait_cnt != '0) begin
              wait_cnt_next = wait_cnt - 15'd1;
            end else if (!ramping && !found) begin
              for (int i = 0; i < sors_pkg::NUM_SERVOS; i++) begin
                last_pos_next[i] = tgt[i];
              end
              running_next = 1'b0;
              slot_next    = '0;
              has_res      = 1'b1;
              res.kind     = sors_pkg::KIND_DONE;
            end else begin
              has_res       = 1'b1;
              res.kind      = sors_pkg::KIND_WRITE;
              res.servo_out = sel_servo;
              res.angle     = cur_ang;
              wait_cnt_next = delay;
              if (cur_ang == tgt_ang) begin
                ramping_next = 1'b0;
                slot_next    = sel_slot + 3'd1;
              end else begin
                ramping_next = 1'b1;
                slot_next    = sel_slot;
                cur_next     = (cur_ang < tgt_ang) ? cur_ang + 8'd1 : cur_ang - 8'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sors_pkg::SERVO_SLOTS; i++) begin
        last_pos[i] <= sors_pkg::home_pos(sors_pkg::NUM_W'(i));
        tgt[i]      <= sors_pkg::home_pos(sors_pkg::NUM_W'(i));
      end
      order    <= '0;
      slot     <= '0;
      cur      <= '0;
      wait_cnt <= '0;
      delay    <= '0;
      running  <= 1'b0;
      ramping  <= 1'b0;
    end else begin
      last_pos <= last_pos_next;
      tgt      <= tgt_next;
      order    <= order_next;
      slot     <= slot_next;
      cur      <= cur_next;
      wait_cnt <= wait_cnt_next;
      delay    <= delay_next;
      running  <= running_next;
      ramping  <= ramping_next;
    end
  end

endmodule

>>> rtl/sors_out_reg.sv
// Result register of the servo ordered ramp sequencer.
// Depends on sors_pkg.
`timescale 1ns / 1ps

module sors_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              has_res,
  input  sors_pkg::result_t res,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output sors_pkg::result_t rsp
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= has_res;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      rsp <= res;
    end
  end

endmodule

>>> rtl/servo_ordered_ramp_sequencer.sv
// Top level of the servo ordered ramp sequencer.
// Depends on sors_pkg, sors_in_reg, sors_core and sors_out_reg.
`timescale 1ns / 1ps

// Ramps up to six servos one after another in a programmed order. A load
// request sets one target, a start request takes the move order and the
// ticks to wait after each one-degree write, and tick requests step the
// ramps; each tick gives at most one angle write, and the end of the order
// gives a done result that commits all targets. One request is taken every
// cycle while the result is not stalled; a request passes the input register
// and one state update into the result register.
// Only a stalled result (rsp_valid high, rsp_ready low) holds back new
// requests.
module servo_ordered_ramp_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  mode,
  input  logic [2:0]  servo_index,
  input  logic [7:0]  target_position,
  input  logic [17:0] move_order,
  input  logic [14:0] step_ticks,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        kind,
  output logic [2:0]  servo_out,
  output logic [7:0]  angle
);

  sors_pkg::item_t   req_item;
  sors_pkg::item_t   item;
  sors_pkg::result_t res;
  sors_pkg::result_t rsp;
  logic              item_valid;
  logic              fire;
  logic              has_res;

  assign req_item.mode            = mode;
  assign req_item.servo_index     = servo_index;
  assign req_item.target_position = target_position;
  assign req_item.move_order      = move_order;
  assign req_item.step_ticks      = step_ticks;

  assign fire = item_valid && (!rsp_valid || rsp_ready);

  sors_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_item   (req_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sors_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (item),
    .has_res (has_res),
    .res     (res)
  );

  sors_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .has_res   (has_res),
    .res       (res),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign kind      = rsp.kind;
  assign servo_out = rsp.servo_out;
  assign angle     = rsp.angle;

endmodule

>>> rtl/sors_checker.sv
// Port-level checks of the servo ordered ramp sequencer, bound to the top.
// Depends on sors_pkg and servo_ordered_ramp_sequencer_assert.svh.
`timescale 1ns / 1ps
`include "servo_ordered_ramp_sequencer_assert.svh"

module sors_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  mode,
  input logic [2:0]  servo_index,
  input logic [7:0]  target_position,
  input logic [17:0] move_order,
  input logic [14:0] step_ticks,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        kind,
  input logic [2:0]  servo_out,
  input logic [7:0]  angle
);

  `SORS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(kind) && $stable(servo_out) && $stable(angle))
  `SORS_ASSERT_IMPL(a_ready_free, !rsp_valid, req_ready)
  `SORS_ASSERT_IMPL(a_done_zero, rsp_valid && kind == sors_pkg::KIND_DONE, servo_out == 3'd0 && angle == 8'd0)
  `SORS_ASSERT_IMPL(a_servo_range, rsp_valid && kind == sors_pkg::KIND_WRITE, servo_out < 3'(sors_pkg::NUM_SERVOS))

endmodule

bind servo_ordered_ramp_sequencer sors_checker u_sors_checker (.*);
